// ===== design/u8u16_pkg.sv =====
package u8u16_pkg;

   localparam int COUNT_BITS = 16;
   localparam int WIDE_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam logic [7:0]  ASCII_MAX   = 8'h7F;
   localparam logic [7:0]  TWO_MAX     = 8'hDF;
   localparam logic [7:0]  LEAD2_MASK  = 8'h1F;
   localparam logic [7:0]  LEAD3_MASK  = 8'h0F;
   localparam logic [7:0]  CONT_MASK   = 8'h3F;
   localparam logic [15:0] REPORT_MAX  = 16'hFFFF;

   localparam logic [1:0] LEFT_NONE = 2'd0;
   localparam logic [1:0] LEFT_ONE  = 2'd1;
   localparam logic [1:0] LEFT_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [15:0] char_count;
      logic        end_of_string;
   } rsp_type;

   typedef struct packed {
      logic [15:0]           partial_value;
      logic [1:0]            bytes_left;
      logic [COUNT_BITS-1:0] chars_seen;
   } dec_state_type;

endpackage

// ===== design/u8u16_step.sv =====
module u8u16_step import u8u16_pkg::*; (
   input  req_type       word,
   input  logic          little_endian,
   input  dec_state_type cur,
   output dec_state_type nxt,
   output logic          emit,
   output rsp_type       result
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [7:0]            b;
   logic [15:0]           unit;
   logic [COUNT_BITS-1:0] chars_inc;
   logic [WIDE_BITS-1:0]  chars_wide;

   always_comb begin
      b         = word.in_byte;
      unit      = '0;
      emit      = 1'b0;
      nxt       = cur;
      chars_inc = cur.chars_seen;
      chars_wide = '0;
      result    = '0;

      case (cur.bytes_left)
         LEFT_NONE: begin
            if (b <= ASCII_MAX) begin
               unit = {8'h00, b};
               emit = 1'b1;
            end else if (b <= TWO_MAX) begin
               nxt.partial_value = {5'b0, b[4:0] & LEAD2_MASK[4:0], 6'b0};
               nxt.bytes_left    = LEFT_ONE;
            end else begin
               nxt.partial_value = {b[3:0] & LEAD3_MASK[3:0], 12'b0};
               nxt.bytes_left    = LEFT_TWO;
            end
         end
         LEFT_TWO: begin
            nxt.partial_value = cur.partial_value | {4'b0, b[5:0] & CONT_MASK[5:0], 6'b0};
            nxt.bytes_left    = LEFT_ONE;
         end
         default: begin
            unit = cur.partial_value | {10'b0, b[5:0] & CONT_MASK[5:0]};
            emit = 1'b1;
         end
      endcase

      // A string that ends inside a sequence emits with the missing bits as zero.
      if (!emit && word.last_byte) begin
         unit = nxt.partial_value;
         emit = 1'b1;
      end

      if (emit) begin
         nxt.partial_value = '0;
         nxt.bytes_left    = LEFT_NONE;
         if (cur.chars_seen != COUNT_MAX) begin
            chars_inc = cur.chars_seen + 1'b1;
         end
         chars_wide = WIDE_BITS'(chars_inc);
         nxt.chars_seen = word.last_byte ? '0 : chars_inc;
         result.code_unit = little_endian ? {unit[7:0], unit[15:8]} : unit;
         result.char_count = (chars_wide > WIDE_BITS'(REPORT_MAX)) ?
                             REPORT_MAX : chars_wide[15:0];
         result.end_of_string = word.last_byte;
      end
   end

endmodule

// ===== design/utf8_to_utf16_decoder.sv =====
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_ready
// rsp      out        rsp_type  rsp_valid / rsp_ready
// csr      in         1 bit     csr_wr_en, no wait
//
// A byte is decoded in the cycle after it is accepted, and its code unit is loaded into
// the result register at the end of that cycle unless that register still holds a stalled result.
// One byte is taken every cycle while the result register drains.
// Reset clears the decode state, the count, the byte order and both valid flags.
// A stalled result blocks new bytes only when the decode stage holds a word
// that also produces a result.
module utf8_to_utf16_decoder import u8u16_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   logic          little_endian_ff;
   logic          in_valid_ff, in_valid_in;
   req_type       in_word_ff;
   dec_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_word_ff;
   logic          emit;
   rsp_type       result;
   logic          out_free, advance;

   u8u16_step step (
      .word          (in_word_ff),
      .little_endian (little_endian_ff),
      .cur           (state_ff),
      .nxt           (state_in),
      .emit          (emit),
      .result        (result)
   );

   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      advance      = !in_valid_ff || !emit || out_free;
      in_valid_in  = advance ? req_valid : in_valid_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (in_valid_ff && emit && out_free) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            little_endian_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_word_ff <= req_word;
      end
      if (in_valid_ff && emit && out_free) begin
         out_word_ff <= result;
      end
   end

   assign req_ready = advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== design/u8u16_checker.sv =====
module u8u16_checker import u8u16_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("Result word changed while stalled.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.char_count != 16'd0)
      else $error("Character count of zero on a result.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_word.end_of_string && rsp_word.char_count != REPORT_MAX
      ##1 rsp_take |-> rsp_word.char_count == 16'($past(rsp_word.char_count) + 16'd1))
      else $error("Character count did not advance by one.");

endmodule

bind utf8_to_utf16_decoder u8u16_checker checker_inst (.*);

// ===== bench/utf8_to_utf16_decoder_checker.sv =====
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_checker import u8u16_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_word,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   output int      mismatches,
   output int      units_pending,
   output int      units_checked
);

   logic [15:0]           partial_unit;
   logic [1:0]            cont_left;
   logic [COUNT_BITS-1:0] chars_in_string;
   logic                  swap_bytes;
   rsp_type               expected_units[$];

   function automatic void predict_unit(input req_type w);
      logic [15:0]          unit;
      logic                 done;
      logic [WIDE_BITS-1:0] wide_count;
      rsp_type              r;
      unit = '0;
      done = 1'b0;
      case (cont_left)
         LEFT_NONE: begin
            if (w.in_byte <= ASCII_MAX) begin
               unit = 16'(w.in_byte);
               done = 1'b1;
            end else if (w.in_byte <= TWO_MAX) begin
               partial_unit = 16'(w.in_byte & LEAD2_MASK) << 6;
               cont_left    = LEFT_ONE;
            end else begin
               partial_unit = 16'(w.in_byte & LEAD3_MASK) << 12;
               cont_left    = LEFT_TWO;
            end
         end
         LEFT_TWO: begin
            partial_unit = partial_unit | (16'(w.in_byte & CONT_MASK) << 6);
            cont_left    = LEFT_ONE;
         end
         default: begin
            unit         = partial_unit | 16'(w.in_byte & CONT_MASK);
            partial_unit = '0;
            cont_left    = LEFT_NONE;
            done         = 1'b1;
         end
      endcase
      // A string that ends inside a sequence still yields its partial character.
      if (!done && w.last_byte) begin
         unit = partial_unit;
         done = 1'b1;
      end
      if (done) begin
         partial_unit = '0;
         cont_left    = LEFT_NONE;
         if (chars_in_string != '1) chars_in_string = chars_in_string + 1'b1;
         wide_count = WIDE_BITS'(chars_in_string);
         r.code_unit     = swap_bytes ? {unit[7:0], unit[15:8]} : unit;
         r.char_count    = (wide_count > WIDE_BITS'(REPORT_MAX)) ? REPORT_MAX
                                                                 : wide_count[15:0];
         r.end_of_string = w.last_byte;
         expected_units.insert(expected_units.size(), r);
         if (w.last_byte) chars_in_string = '0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_unit;
      if (reset) begin
         partial_unit    = '0;
         cont_left       = LEFT_NONE;
         chars_in_string = '0;
         swap_bytes      = 1'b0;
         expected_units.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            units_checked = units_checked + 1;
            if (expected_units.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Unexpected code unit %h count %0d end %b with nothing pending",
                           rsp_word.code_unit, rsp_word.char_count, rsp_word.end_of_string);
            end else begin
               exp_unit = expected_units.pop_front();
               if (rsp_word.code_unit !== exp_unit.code_unit ||
                   rsp_word.char_count !== exp_unit.char_count ||
                   rsp_word.end_of_string !== exp_unit.end_of_string) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("Code unit %0d: expected %h count %0d end %b, %s %h %0d %b",
                              units_checked, exp_unit.code_unit, exp_unit.char_count,
                              exp_unit.end_of_string, "got", rsp_word.code_unit,
                              rsp_word.char_count, rsp_word.end_of_string);
               end
            end
         end
         if (req_valid && req_ready) predict_unit(req_word);
         if (csr_wr_en) swap_bytes = csr_wr_data;
      end
      units_pending = expected_units.size();
   end

endmodule

// ===== bench/utf8_to_utf16_decoder_test.sv =====
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_test;
   import u8u16_pkg::*;

   localparam int IDLE_LIMIT = 1000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_word    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_word;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   int mismatches;
   int units_pending;
   int units_checked;
   int idle_cycles = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   bit quiet = 1'b0;

   always #4 clock = ~clock;

   utf8_to_utf16_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   utf8_to_utf16_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatches    (mismatches),
      .units_pending (units_pending),
      .units_checked (units_checked)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("No word moved for %0d cycles.", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int hold;
      forever begin
         @(posedge clock);
         hold = pick_gap();
         if (hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= '{in_byte: b, last_byte: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent = bytes_sent + 1;
      if (last) strings_sent = strings_sent + 1;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (units_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_byte_order(input logic swap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= swap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_bytes(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
   endtask

   task automatic run_directed();
      send_bytes('{8'h00});
      send_bytes('{8'h7F, 8'h41});
      send_bytes('{8'h80, 8'h80, 8'hDF, 8'hBF});
      send_bytes('{8'hE0, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF});
      send_bytes('{8'hEF, 8'h00, 8'h3F, 8'hC3});
      send_bytes('{8'hE5, 8'h9C});
      send_bytes('{8'hE5});
      send_bytes('{8'hC2, 8'hC0, 8'h5A});
   endtask

   function automatic logic [7:0] pick_continuation();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   task automatic send_utf8_string();
      logic [7:0] seq[$];
      logic [7:0] lead;
      int         nchars;
      int         len;
      nchars = $urandom_range(1, 10);
      len    = 1;
      for (int c = 0; c < nchars; c++) begin
         case ($urandom_range(0, 2))
            0: begin
               len  = 1;
               lead = 8'($urandom_range(0, 8'h7F));
            end
            1: begin
               len = 2;
               if ($urandom_range(0, 5) == 0) lead = 8'($urandom_range(8'h80, 8'hBF));
               else lead = 8'($urandom_range(8'hC0, 8'hDF));
            end
            default: begin
               len  = 3;
               lead = 8'($urandom_range(8'hE0, 8'hFF));
            end
         endcase
         seq.insert(seq.size(), lead);
         for (int k = 1; k < len; k++) seq.insert(seq.size(), pick_continuation());
      end
      // Now and then the string stops inside its final character.
      if (len > 1 && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
      end
      send_bytes(seq);
   endtask

   task automatic run_random(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         quiet = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) < 8) begin
            send_utf8_string();
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         set_byte_order(phase % 2 == 1);
         if (phase < 2) run_directed();
         run_random(450);
      end
      send_utf8_string();
      wait_idle();
      $display("Decoded %0d bytes in %0d strings under both byte orders, %0d units checked,",
               bytes_sent, strings_sent, units_checked);
      $display("including truncated strings and unchecked continuation bytes.");
      if (mismatches == 0 && units_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d code units still outstanding.", mismatches,
                  units_pending);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
